@@ rtl/wide_bit_vector_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Wide bit vector unit assertion macros
// Concurrent assertion helpers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WIDE_BIT_VECTOR_UNIT_DEFINES_SVH
`define WIDE_BIT_VECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define WBV_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("wbv check failed");
`define WBV_ASSERT_NEXT(label, clk, rst_n, trig, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) else $error("wbv check failed");
`else
`define WBV_ASSERT(label, clk, rst_n, prop)
`define WBV_ASSERT_NEXT(label, clk, rst_n, trig, expr)
`endif
`endif

@@ rtl/wbv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide bit vector unit package
// Command codes, shift modes, cell control and the word mask function.
// ----------------------------------------------------------------------------
package wbv_pkg;

	localparam int WORD_BITS = 32;

	localparam logic [3:0] CMD_WRITE = 4'd0;
	localparam logic [3:0] CMD_READ  = 4'd1;
	localparam logic [3:0] CMD_AND   = 4'd2;
	localparam logic [3:0] CMD_OR    = 4'd3;
	localparam logic [3:0] CMD_NAND  = 4'd4;
	localparam logic [3:0] CMD_NOR   = 4'd5;
	localparam logic [3:0] CMD_XOR   = 4'd6;
	localparam logic [3:0] CMD_EQU   = 4'd7;
	localparam logic [3:0] CMD_INV   = 4'd8;
	localparam logic [3:0] CMD_SHIFT = 4'd9;
	localparam logic [3:0] CMD_INC   = 4'd10;
	localparam logic [3:0] CMD_COUNT = 4'd11;
	localparam logic [3:0] CMD_FIND  = 4'd12;

	localparam logic [1:0] SH_KEEP  = 2'd0;
	localparam logic [1:0] SH_ZERO  = 2'd1;
	localparam logic [1:0] SH_LEFT  = 2'd2;
	localparam logic [1:0] SH_RIGHT = 2'd3;

	localparam logic [11:0] NUM_NONE = 12'hFFF;

	typedef struct packed {
		logic step;
		logic clear;
	} wbv_ctl_t;

	// Valid bits of word k for an active length of len bits.
	function automatic logic [31:0] word_mask(input logic [15:0] k, input logic [15:0] len);
		logic [15:0] n;
		logic [15:0] rem;
		n = (len + 16'd31) >> 5;
		rem = len - ((n - 16'd1) << 5);
		if (k >= n) begin
			return 32'd0;
		end else if ((k + 16'd1) < n || rem >= 16'd32) begin
			return 32'hFFFF_FFFF;
		end else begin
			return (32'd1 << rem[4:0]) - 32'd1;
		end
	endfunction

endpackage

@@ rtl/wbv_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide bit vector unit channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wbv_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         cmd;
	logic [4:0]         word_index;
	logic [31:0]        operand_word;
	logic signed [11:0] shift_amount;
	logic [9:0]         start_index;

	modport source (output valid, cmd, word_index, operand_word, shift_amount, start_index,
		input ready);
	modport sink (input valid, cmd, word_index, operand_word, shift_amount, start_index,
		output ready);
endinterface

interface wbv_rsp_if;
	logic               valid;
	logic               ready;
	logic [31:0]        data_word;
	logic signed [11:0] number;

	modport source (output valid, data_word, number, input ready);
	modport sink (input valid, data_word, number, output ready);
endinterface

@@ rtl/wbv_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide bit vector cell
// Holds one word of the vector and passes it to its neighbor on each step.
// ----------------------------------------------------------------------------
module wbv_cell #(
	parameter int MAX_WORDS = 32,
	parameter int IDX = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  wbv_pkg::wbv_ctl_t                      ctl,
	input  logic [$clog2(MAX_WORDS*32+1)-1:0]      len,
	input  logic [31:0]                            d_in,
	output logic [31:0]                            word
);
	logic [31:0] word_q;
	logic [31:0] mask;

	assign mask = wbv_pkg::word_mask(16'(IDX), 16'(len));
	assign word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= 32'd0;
		end else if (ctl.step) begin
			word_q <= d_in;
		end else if (ctl.clear) begin
			word_q <= word_q & mask;
		end
	end
endmodule

@@ rtl/wbv_head.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide bit vector head unit
// Sequences the ring passes and processes the word leaving the first cell.
// ----------------------------------------------------------------------------
module wbv_head #(
	parameter int MAX_WORDS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [3:0]                         cmd,
	input  logic [4:0]                         word_index,
	input  logic [31:0]                        operand_word,
	input  logic signed [11:0]                 shift_amount,
	input  logic [9:0]                         start_index,
	input  logic [$clog2(MAX_WORDS*32+1)-1:0]  len,
	input  logic [31:0]                        c0,
	input  logic                               out_free,
	output logic                               busy,
	output logic                               step,
	output logic [31:0]                        push,
	output logic                               done,
	output logic [31:0]                        data,
	output logic [11:0]                        number
);
	localparam int PW = $clog2(MAX_WORDS + 2);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PASS_A = 2'd1;
	localparam logic [1:0] ST_PASS_B = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]    state_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] alast_q;
	logic [3:0]    cmd_q;
	logic [4:0]    idx_q;
	logic [31:0]   opw_q;
	logic [9:0]    start_q;
	logic [1:0]    mode_q;
	logic [PW-1:0] q_q;
	logic [4:0]    r_q;
	logic [31:0]   prev_q;
	logic          carry_q;
	logic          found_q;
	logic [31:0]   data_q;
	logic [11:0]   num_q;

	logic [11:0]   shift_dist;
	logic [1:0]    mode_in;
	logic [PW-1:0] q_in;
	logic [PW-1:0] blast;
	logic [15:0]   pos16;
	logic [31:0]   m_pos;
	logic [31:0]   m_prev;
	logic [31:0]   c_in;
	logic [31:0]   x;
	logic [31:0]   lv;
	logic [31:0]   inc_v;
	logic [31:0]   smask;
	logic [31:0]   cand;
	logic [4:0]    lsb;
	logic [5:0]    rinv;
	logic          hit;
	logic [31:0]   push_b;

	assign shift_dist = shift_amount[11] ? 12'(-shift_amount) : 12'(shift_amount);
	assign q_in = PW'(shift_dist[11:5]);

	always_comb begin
		if (cmd != wbv_pkg::CMD_SHIFT || shift_dist == 12'd0) begin
			mode_in = wbv_pkg::SH_KEEP;
		end else if ({4'd0, shift_dist} >= 16'(len)) begin
			mode_in = wbv_pkg::SH_ZERO;
		end else if (shift_amount[11]) begin
			mode_in = wbv_pkg::SH_RIGHT;
		end else begin
			mode_in = wbv_pkg::SH_LEFT;
		end
	end

	assign blast = (mode_q == wbv_pkg::SH_RIGHT) ? PW'(MAX_WORDS) : PW'(MAX_WORDS - 1);
	assign pos16 = 16'(pos_q);
	assign m_pos = wbv_pkg::word_mask(pos16, 16'(len));
	assign m_prev = wbv_pkg::word_mask(pos16 - 16'd1, 16'(len));
	assign c_in = (pos16 < 16'(MAX_WORDS)) ? c0 : 32'd0;
	assign x = (mode_q == wbv_pkg::SH_LEFT && pos_q < q_q) ? 32'd0 : c_in;
	assign hit = (pos16 == 16'(idx_q));
	assign rinv = 6'd32 - {1'b0, r_q};
	assign inc_v = (c0 + {31'd0, carry_q}) & m_pos;

	always_comb begin
		if (pos16 > 16'(start_q[9:5])) begin
			smask = 32'hFFFF_FFFF;
		end else if (pos16 == 16'(start_q[9:5])) begin
			smask = 32'hFFFF_FFFF << start_q[4:0];
		end else begin
			smask = 32'd0;
		end
	end
	assign cand = c0 & smask;

	always_comb begin
		lsb = 5'd0;
		for (int b = 31; b >= 0; b--) begin
			if (cand[b]) begin
				lsb = 5'(b);
			end
		end
	end

	always_comb begin
		case (cmd_q)
			wbv_pkg::CMD_AND:  lv = c0 & opw_q;
			wbv_pkg::CMD_OR:   lv = c0 | opw_q;
			wbv_pkg::CMD_NAND: lv = ~(c0 & opw_q);
			wbv_pkg::CMD_NOR:  lv = ~(c0 | opw_q);
			wbv_pkg::CMD_XOR:  lv = c0 ^ opw_q;
			default:           lv = ~(c0 ^ opw_q);
		endcase
		lv = lv & m_pos;
	end

	always_comb begin
		push_b = c0;
		unique case (mode_q)
			wbv_pkg::SH_ZERO: begin
				push_b = 32'd0;
			end
			wbv_pkg::SH_LEFT: begin
				push_b = ((x << r_q) | ((r_q != 5'd0) ? (prev_q >> rinv) : 32'd0)) & m_pos;
			end
			wbv_pkg::SH_RIGHT: begin
				if (pos_q == '0) begin
					push_b = 32'd0;
				end else begin
					push_b = ((prev_q >> r_q) | ((r_q != 5'd0) ? (x << rinv) : 32'd0)) & m_prev;
				end
			end
			default: begin
				case (cmd_q)
					wbv_pkg::CMD_WRITE: push_b = hit ? (opw_q & m_pos) : c0;
					wbv_pkg::CMD_AND, wbv_pkg::CMD_OR, wbv_pkg::CMD_NAND,
					wbv_pkg::CMD_NOR, wbv_pkg::CMD_XOR, wbv_pkg::CMD_EQU:
						push_b = hit ? lv : c0;
					wbv_pkg::CMD_INV:   push_b = ~c0 & m_pos;
					wbv_pkg::CMD_INC:   push_b = inc_v;
					default:            push_b = c0;
				endcase
			end
		endcase
	end

	always_comb begin
		step = 1'b0;
		push = push_b;
		if (state_q == ST_PASS_A) begin
			step = 1'b1;
			push = (mode_q == wbv_pkg::SH_LEFT) ? c0 : 32'd0;
		end else if (state_q == ST_PASS_B) begin
			step = 1'b1;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE) && out_free;
	assign data = data_q;
	assign number = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						pos_q <= '0;
						if ((mode_in == wbv_pkg::SH_LEFT || mode_in == wbv_pkg::SH_RIGHT)
							&& q_in != '0) begin
							state_q <= ST_PASS_A;
						end else begin
							state_q <= ST_PASS_B;
						end
					end
				end
				ST_PASS_A: begin
					if (pos_q == alast_q) begin
						pos_q <= '0;
						state_q <= ST_PASS_B;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_PASS_B: begin
					if (pos_q == blast) begin
						state_q <= ST_DONE;
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
			idx_q <= word_index;
			opw_q <= operand_word;
			start_q <= start_index;
			mode_q <= mode_in;
			q_q <= q_in;
			r_q <= shift_dist[4:0];
			alast_q <= (mode_in == wbv_pkg::SH_LEFT) ? (PW'(MAX_WORDS - 1) - q_in)
				: (q_in - 1'b1);
			prev_q <= 32'd0;
			carry_q <= 1'b1;
			found_q <= 1'b0;
			data_q <= 32'd0;
			num_q <= (cmd == wbv_pkg::CMD_FIND) ? wbv_pkg::NUM_NONE : 12'd0;
		end else if (state_q == ST_PASS_A) begin
			prev_q <= 32'd0;
		end else if (state_q == ST_PASS_B) begin
			prev_q <= x;
			carry_q <= carry_q && (inc_v == 32'd0);
			case (cmd_q)
				wbv_pkg::CMD_READ: begin
					if (hit) begin
						data_q <= c0;
					end
				end
				wbv_pkg::CMD_AND, wbv_pkg::CMD_OR, wbv_pkg::CMD_NAND,
				wbv_pkg::CMD_NOR, wbv_pkg::CMD_XOR, wbv_pkg::CMD_EQU: begin
					if (hit) begin
						data_q <= lv;
					end
				end
				wbv_pkg::CMD_COUNT: begin
					num_q <= num_q + 12'($countones(c0));
				end
				wbv_pkg::CMD_FIND: begin
					if (!found_q && cand != 32'd0) begin
						found_q <= 1'b1;
						num_q <= 12'((pos16 << 5) | 16'(lsb));
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

@@ rtl/wide_bit_vector_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide bit vector unit
// Multiword bit vector ALU built as a ring of word cells around a head unit.
// ----------------------------------------------------------------------------
// Each request rotates the ring of MAX_WORDS cells through the head unit one
// word per cycle. A right shift by q whole words first drops q words; a left
// shift by q whole words, q above zero, first turns the ring by MAX_WORDS - q
// words. A new request is taken while the previous response waits.
module wide_bit_vector_unit #(
	parameter int MAX_WORDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	wbv_req_if.sink     req,
	wbv_rsp_if.source   rsp
);
	`include "wide_bit_vector_unit_defines.svh"

	localparam int LW = $clog2(MAX_WORDS * 32 + 1);
	localparam int LEN_MAX = MAX_WORDS * 32;
	localparam int LEN_RST = (LEN_MAX < 1024) ? LEN_MAX : 1024;

	logic [LW-1:0]     len_q;
	logic [LW-1:0]     len_new;
	logic [31:0]       cell_word [MAX_WORDS];
	logic [31:0]       push;
	logic              head_busy;
	logic              head_step;
	logic              head_done;
	logic [31:0]       head_data;
	logic [11:0]       head_number;
	logic              out_free;
	logic              out_valid_q;
	logic [31:0]       out_data_q;
	logic [11:0]       out_num_q;
	wbv_pkg::wbv_ctl_t cell_ctl;

	always_comb begin
		if (cfg_wdata == 11'd0) begin
			len_new = LW'(1);
		end else if ({5'd0, cfg_wdata} > 16'(LEN_MAX)) begin
			len_new = LW'(LEN_MAX);
		end else begin
			len_new = LW'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(LEN_RST);
		end else if (cfg_we) begin
			len_q <= len_new;
		end
	end

	assign cell_ctl = '{step: head_step, clear: cfg_we};

	for (genvar i = 0; i < MAX_WORDS; i++) begin : g_ring
		logic [31:0] d_in;
		if (i == MAX_WORDS - 1) begin : g_tail
			assign d_in = push;
		end else begin : g_link
			assign d_in = cell_word[i+1];
		end
		wbv_cell #(
			.MAX_WORDS(MAX_WORDS),
			.IDX(i)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (cell_ctl),
			.len   (len_new),
			.d_in  (d_in),
			.word  (cell_word[i])
		);
	end

	assign out_free = !out_valid_q || rsp.ready;

	wbv_head #(
		.MAX_WORDS(MAX_WORDS)
	) u_head (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (req.valid && req.ready),
		.cmd         (req.cmd),
		.word_index  (req.word_index),
		.operand_word(req.operand_word),
		.shift_amount(req.shift_amount),
		.start_index (req.start_index),
		.len         (len_q),
		.c0          (cell_word[0]),
		.out_free    (out_free),
		.busy        (head_busy),
		.step        (head_step),
		.push        (push),
		.done        (head_done),
		.data        (head_data),
		.number      (head_number)
	);

	assign req.ready = !head_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (head_done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (head_done) begin
			out_data_q <= head_data;
			out_num_q <= head_number;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data_word = out_data_q;
	assign rsp.number = out_num_q;

	`WBV_ASSERT(a_done_has_room, clk, arst_n, head_done |-> (!out_valid_q || rsp.ready))
	`WBV_ASSERT_NEXT(a_accept_busy, clk, arst_n, req.valid && req.ready, !req.ready)
	`WBV_ASSERT_NEXT(a_done_shows, clk, arst_n, head_done, rsp.valid)
endmodule

@@ verif/wide_bit_vector_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide bit vector unit testbench
// Drives word, logic and whole-vector commands over several vector lengths
// with random idling and back pressure, and checks every response against a
// bit-accurate model of the vector store kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module wide_bit_vector_unit_tb;

	localparam int NWORDS = 32;
	localparam int MAX_BITS = NWORDS * 32;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic [3:0]         cmd;
		logic [4:0]         word_index;
		logic [31:0]        operand_word;
		logic signed [11:0] shift_amount;
		logic [9:0]         start_index;
	} request_t;

	typedef struct packed {
		logic [31:0]        data_word;
		logic signed [11:0] number;
	} response_t;

	class vector_scoreboard;
		logic [31:0] store [NWORDS];
		int unsigned length_bits;
		response_t pending [$];
		int unsigned errors;
		int unsigned checked;

		function new();
			foreach (store[i]) store[i] = '0;
			length_bits = 1024;
			errors = 0;
			checked = 0;
		endfunction

		function int unsigned active_len();
			if (length_bits < 1) return 1;
			if (length_bits > MAX_BITS) return MAX_BITS;
			return length_bits;
		endfunction

		function logic [31:0] valid_bits(int unsigned k, int unsigned len);
			int unsigned n;
			int unsigned rem;
			n = (len + 31) / 32;
			if (k >= n) return '0;
			if (k + 1 < n) return '1;
			rem = len - 32 * (n - 1);
			if (rem >= 32) return '1;
			return (32'd1 << rem) - 32'd1;
		endfunction

		function void set_length(logic [10:0] value);
			int unsigned len;
			length_bits = value;
			len = active_len();
			foreach (store[i]) store[i] &= valid_bits(i, len);
		endfunction

		function logic get_bit(int p);
			if (p < 0 || p >= MAX_BITS) return 1'b0;
			return store[p / 32][p % 32];
		endfunction

		function void note_request(request_t r);
			int unsigned len;
			int unsigned n;
			logic [31:0] a;
			logic [31:0] v;
			logic [MAX_BITS-1:0] flat;
			logic [MAX_BITS-1:0] moved;
			int shift_by;
			response_t res;
			len = active_len();
			n = (len + 31) / 32;
			res = '0;
			case (r.cmd)
				wbv_pkg::CMD_WRITE: begin
					if (r.word_index < n) store[r.word_index] = r.operand_word &
						valid_bits(r.word_index, len);
				end
				wbv_pkg::CMD_READ: begin
					if (r.word_index < n) res.data_word = store[r.word_index];
				end
				wbv_pkg::CMD_AND, wbv_pkg::CMD_OR, wbv_pkg::CMD_NAND, wbv_pkg::CMD_NOR,
				wbv_pkg::CMD_XOR, wbv_pkg::CMD_EQU: begin
					if (r.word_index < n) begin
						a = store[r.word_index];
						case (r.cmd)
							wbv_pkg::CMD_AND: v = a & r.operand_word;
							wbv_pkg::CMD_OR: v = a | r.operand_word;
							wbv_pkg::CMD_NAND: v = ~(a & r.operand_word);
							wbv_pkg::CMD_NOR: v = ~(a | r.operand_word);
							wbv_pkg::CMD_XOR: v = a ^ r.operand_word;
							default: v = ~(a ^ r.operand_word);
						endcase
						v &= valid_bits(r.word_index, len);
						store[r.word_index] = v;
						res.data_word = v;
					end
				end
				wbv_pkg::CMD_INV: begin
					for (int i = 0; i < n; i++) store[i] = ~store[i] & valid_bits(i, len);
				end
				wbv_pkg::CMD_SHIFT: begin
					shift_by = r.shift_amount;
					if (shift_by != 0) begin
						for (int i = 0; i < NWORDS; i++) flat[i*32 +: 32] = store[i];
						if ((shift_by < 0 ? -shift_by : shift_by) >= len) moved = '0;
						else if (shift_by > 0) moved = flat << shift_by;
						else moved = flat >> (-shift_by);
						for (int i = 0; i < NWORDS; i++)
							store[i] = moved[i*32 +: 32] & valid_bits(i, len);
					end
				end
				wbv_pkg::CMD_INC: begin
					for (int i = 0; i < n; i++) begin
						store[i] = (store[i] + 32'd1) & valid_bits(i, len);
						if (store[i] != 0) break;
					end
				end
				wbv_pkg::CMD_COUNT: begin
					for (int i = 0; i < n; i++) res.number += 12'($countones(store[i]));
				end
				wbv_pkg::CMD_FIND: begin
					res.number = wbv_pkg::NUM_NONE;
					for (int p = r.start_index; p < len; p++) begin
						if (get_bit(p)) begin
							res.number = 12'(p);
							break;
						end
					end
				end
				default: ;
			endcase
			pending.push_back(res);
		endfunction

		function void check_response(response_t got);
			response_t want;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected response data_word=%h number=%0d", got.data_word, got.number);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.data_word !== want.data_word) begin
				$error("data_word: expected %h actual %h", want.data_word, got.data_word);
				errors++;
			end
			if (got.number !== want.number) begin
				$error("number: expected %0d actual %0d", want.number, got.number);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [10:0] cfg_wdata;
	longint cycles;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned hold_cycles;
	int unsigned sent;
	vector_scoreboard board;

	wbv_req_if req ();
	wbv_rsp_if rsp ();

	wide_bit_vector_unit #(.MAX_WORDS(NWORDS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req(req.sink),
		.rsp(rsp.source)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("** wide_bit_vector_unit: FAILED **");
				$finish;
			end
		end
	end

	// Response side: random stalls, plus a long hold-off when requested.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp.valid && rsp.ready)
				board.check_response('{data_word: rsp.data_word, number: rsp.number});
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic request_t random_request();
		request_t r;
		int unsigned pick;
		r.cmd = 4'($urandom_range(15));
		pick = $urandom_range(99);
		if (pick < 40) r.cmd = 4'($urandom_range(int'(wbv_pkg::CMD_EQU)));
		else if (pick < 90) r.cmd = 4'($urandom_range(int'(wbv_pkg::CMD_FIND)));
		r.word_index = 5'($urandom);
		r.operand_word = $urandom;
		case ($urandom_range(3))
			0: r.shift_amount = 12'($urandom);
			1: r.shift_amount = 12'($signed($urandom_range(80)) - 40);
			2: r.shift_amount = 12'($signed($urandom_range(2048)) - 1024);
			default: r.shift_amount = ($urandom_range(1)) ? 12'sd1024 : -12'sd1024;
		endcase
		r.start_index = 10'($urandom);
		return r;
	endfunction

	task automatic send_request(request_t r);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= r.cmd;
		req.word_index <= r.word_index;
		req.operand_word <= r.operand_word;
		req.shift_amount <= r.shift_amount;
		req.start_index <= r.start_index;
		do @(posedge clk); while (!req.ready);
		board.note_request(r);
		sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_length(logic [10:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_length(value);
		@(posedge clk);
	endtask

	task automatic send_op(logic [3:0] c, logic [4:0] w, logic [31:0] d,
			logic signed [11:0] s, logic [9:0] st);
		send_request('{cmd: c, word_index: w, operand_word: d, shift_amount: s,
			start_index: st});
	endtask

	initial begin
		logic [10:0] lengths [8];
		board = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.cmd = '0;
		req.word_index = '0;
		req.operand_word = '0;
		req.shift_amount = '0;
		req.start_index = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset length, then at a length of 40 bits.
		send_op(wbv_pkg::CMD_FIND, 0, 0, 0, 0);
		send_op(wbv_pkg::CMD_WRITE, 0, 32'hFFFF_FFFF, 0, 0);
		send_op(wbv_pkg::CMD_WRITE, 31, 32'h8000_0001, 0, 0);
		send_op(wbv_pkg::CMD_READ, 31, 0, 0, 0);
		send_op(wbv_pkg::CMD_AND, 0, 32'h0F0F_0F0F, 0, 0);
		send_op(wbv_pkg::CMD_OR, 1, 32'hA5A5_A5A5, 0, 0);
		send_op(wbv_pkg::CMD_NAND, 2, 32'h0, 0, 0);
		send_op(wbv_pkg::CMD_NOR, 3, 32'h1234_5678, 0, 0);
		send_op(wbv_pkg::CMD_XOR, 4, 32'hFFFF_FFFF, 0, 0);
		send_op(wbv_pkg::CMD_EQU, 5, 32'h0, 0, 0);
		send_op(wbv_pkg::CMD_COUNT, 0, 0, 0, 0);
		send_op(wbv_pkg::CMD_FIND, 0, 0, 0, 10'd1023);
		send_op(wbv_pkg::CMD_SHIFT, 0, 0, 12'sd33, 0);
		send_op(wbv_pkg::CMD_SHIFT, 0, 0, -12'sd65, 0);
		send_op(wbv_pkg::CMD_SHIFT, 0, 0, 12'sd0, 0);
		send_op(wbv_pkg::CMD_INV, 0, 0, 0, 0);
		send_op(wbv_pkg::CMD_INC, 0, 0, 0, 0);
		send_op(wbv_pkg::CMD_COUNT, 0, 0, 0, 0);
		send_op(wbv_pkg::CMD_SHIFT, 0, 0, -12'sd1024, 0);
		send_op(4'd13, 7, 32'hDEAD_BEEF, 0, 0);
		send_op(4'd15, 0, 0, 0, 0);
		write_length(11'd40);
		send_op(wbv_pkg::CMD_WRITE, 5, 32'hFFFF_FFFF, 0, 0);
		send_op(wbv_pkg::CMD_READ, 5, 0, 0, 0);
		send_op(wbv_pkg::CMD_SHIFT, 0, 0, 12'sd40, 0);

		lengths = '{11'd1, 11'd0, 11'd2047, 11'd33, 11'd1023, 11'd1000, 11'd64, 11'd1024};
		idle_pct = 16;
		stall_pct = 16;
		foreach (lengths[p]) begin
			write_length(lengths[p]);
			send_op(wbv_pkg::CMD_INV, 0, 0, 0, 0);
			send_op(wbv_pkg::CMD_INC, 0, 0, 0, 0);
			for (int i = 0; i < 200; i++) begin
				if (p == 2 && i == 50) hold_cycles = 600;
				if (p == 4) begin
					idle_pct = 0;
					stall_pct = 0;
				end
				if (p == 3 && i == 100) drain();
				send_request(random_request());
			end
			idle_pct = 16;
			stall_pct = 16;
		end

		drain();
		$display("Sent %0d requests over eight vector lengths, checked %0d responses.",
			sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("** wide_bit_vector_unit: PASSED **");
		else
			$display("** wide_bit_vector_unit: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/wbv_pkg.sv
rtl/wbv_ifs.sv
rtl/wbv_cell.sv
rtl/wbv_head.sv
rtl/wide_bit_vector_unit.sv
verif/wide_bit_vector_unit_tb.sv
